FILE: hw/rtl/lrs_pkg.sv
// lrs_pkg: shared constants and types for the LRU recency stack.
// Used by lrs_cell and lru_recency_stack; depends on nothing.
package lrs_pkg;

   localparam int DEPTH = 16;
   localparam int KEY_W = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OUT_CNT_W = 5;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_TOUCH  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_EMPTY      = 2'd1,
      ST_TOUCH_MISS = 2'd2,
      ST_FULL       = 2'd3
   } status_type;

   // per-word control broadcast to every cell
   typedef struct packed {
      logic ins;      // insert accepted and stack not full
      logic rmv;      // remove accepted and stack not empty
      logic tch;      // touch accepted
      logic tch_hit;  // some cell matched the touch key
   } ctrl_type;

endpackage

FILE: hw/rtl/lrs_cell.sv
// lrs_cell: one slot of the recency chain (key, valid bit, match logic).
// Depends on lrs_pkg.
module lrs_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  lrs_pkg::ctrl_type           ctrl,
   input  logic [lrs_pkg::KEY_W-1:0]   req_key,
   input  logic [lrs_pkg::KEY_W-1:0]   prev_key,
   input  logic                        prev_vld,
   input  logic                        next_vld,
   input  logic                        hit_in,
   input  logic [lrs_pkg::KEY_W-1:0]   rmv_in,
   output logic [lrs_pkg::KEY_W-1:0]   key,
   output logic                        vld,
   output logic                        hit_out,
   output logic [lrs_pkg::KEY_W-1:0]   rmv_out
);
   import lrs_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic             vld_ff, vld_in;
   logic             match, last, shift;

   assign match   = vld_ff && (key_ff == req_key);
   assign hit_out = hit_in | match;
   assign last    = vld_ff & ~next_vld;
   assign rmv_out = rmv_in | (key_ff & {KEY_W{last}});

   // touch: cells from the front down to the first match take the neighbor's key
   assign shift = ctrl.ins | (ctrl.tch & ctrl.tch_hit & ~hit_in);

   always_comb begin
      key_in = shift ? prev_key : key_ff;
      vld_in = vld_ff;
      if (ctrl.ins) begin
         vld_in = prev_vld;
      end else if (ctrl.rmv && last) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign key = key_ff;
   assign vld = vld_ff;

endmodule

FILE: hw/rtl/lru_recency_stack.sv
// lru_recency_stack: bounded most-recent-first key list as a chain of cells.
// The result word is registered in the cycle after the command word is accepted.
// Throughput: one command per cycle while req_stall is low; the whole chain shifts in that cycle.
// Reset clears every cell's valid bit, the count and the result valid flag;
// stored keys and result fields are not reset.
// Depends on lrs_pkg and lrs_cell.
module lru_recency_stack (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_cmd,
   input  logic signed [lrs_pkg::KEY_W-1:0]     req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lrs_pkg::KEY_W-1:0]     rsp_removed_key,
   output logic [1:0]                           rsp_status,
   output logic [lrs_pkg::OUT_CNT_W-1:0]        rsp_entry_count
);
   import lrs_pkg::*;

   logic [KEY_W-1:0] keys_w [DEPTH];
   logic [KEY_W-1:0] rmv_w  [DEPTH+1];
   logic             vld_w  [DEPTH];
   logic             hit_w  [DEPTH+1];

   ctrl_type   ctrl;
   cmd_type    cmd;
   status_type status;
   logic       accept, full, empty;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]       rkey_ff, rkey_in;
   logic [1:0]             rstat_ff, rstat_in;
   logic [CNT_W-1:0]       rcnt_ff, rcnt_in;
   logic [CNT_W+OUT_CNT_W-1:0] rcnt_ext;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign cmd       = cmd_type'(req_cmd);
   assign full      = vld_w[DEPTH-1];
   assign empty     = ~vld_w[0];

   assign hit_w[0] = 1'b0;
   assign rmv_w[0] = '0;

   always_comb begin
      ctrl.ins     = accept && (cmd == CMD_INSERT) && !full;
      ctrl.rmv     = accept && (cmd == CMD_REMOVE) && !empty;
      ctrl.tch     = accept && (cmd == CMD_TOUCH);
      ctrl.tch_hit = hit_w[DEPTH];
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [KEY_W-1:0] prev_key;
         logic             prev_vld, next_vld;
         if (i == 0) begin : g_front
            assign prev_key = req_key;
            assign prev_vld = 1'b1;
         end else begin : g_mid
            assign prev_key = keys_w[i-1];
            assign prev_vld = vld_w[i-1];
         end
         if (i == DEPTH-1) begin : g_back
            assign next_vld = 1'b0;
         end else begin : g_inner
            assign next_vld = vld_w[i+1];
         end
         lrs_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .req_key  (req_key),
            .prev_key (prev_key),
            .prev_vld (prev_vld),
            .next_vld (next_vld),
            .hit_in   (hit_w[i]),
            .rmv_in   (rmv_w[i]),
            .key      (keys_w[i]),
            .vld      (vld_w[i]),
            .hit_out  (hit_w[i+1]),
            .rmv_out  (rmv_w[i+1])
         );
      end
   endgenerate

   always_comb begin
      status = ST_OK;
      case (cmd)
         CMD_INSERT: if (full) status = ST_FULL;
         CMD_REMOVE: if (empty) status = ST_EMPTY;
         CMD_TOUCH:  if (!hit_w[DEPTH]) status = ST_TOUCH_MISS;
         default:    status = ST_OK;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.rmv) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rkey_in      = rkey_ff;
      rstat_in     = rstat_ff;
      rcnt_in      = rcnt_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rkey_in      = ctrl.rmv ? rmv_w[DEPTH] : '0;
         rstat_in     = status;
         rcnt_in      = count_in;
      end
   end

   always_ff @(posedge clock) begin
      rkey_ff  <= rkey_in;
      rstat_ff <= rstat_in;
      rcnt_ff  <= rcnt_in;
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // count reported modulo 32
   assign rcnt_ext        = {{OUT_CNT_W{1'b0}}, rcnt_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_removed_key = rkey_ff;
   assign rsp_status      = rstat_ff;
   assign rsp_entry_count = rcnt_ext[OUT_CNT_W-1:0];

endmodule
